>>> rtl/fragment_reassembler_defines.svh
// Assertion macros shared by the fragment reassembler RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FRAGMENT_REASSEMBLER_DEFINES_SVH
`define FRAGMENT_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define FR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fragment reassembler check failed");

// Next-cycle implication, masked while reset is asserted.
`define FR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fragment reassembler check failed");

`endif

>>> rtl/fr_pkg.sv
// Package for the fragment reassembler: payload structs and constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package fr_pkg;

    localparam int unsigned MAX_FRAGMENT_BYTES = 64;
    localparam logic [15:0] SIZE_LIMIT         = 16'd65532;
    localparam int unsigned MID_DEPTH          = 4;
    localparam int unsigned MID_PTR_W          = $clog2(MID_DEPTH);
    localparam int unsigned MID_CNT_W          = $clog2(MID_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  message_id;
        logic [13:0] fragment_offset;
        logic        more_fragments;
        logic [7:0]  fragment_length;
        logic [7:0]  byte_index;
        logic [7:0]  payload_byte;
        logic        fragment_end;
    } t_frag_in;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_byte;
        logic        message_done;
        logic [15:0] total_size;
    } t_frag_out;

    // Classified item passed from the front end to the back end
    typedef struct packed {
        logic        wr_cand;
        logic        done;
        logic [15:0] base;
        logic [7:0]  idx;
        logic [7:0]  len;
        logic [7:0]  data;
    } t_mid;

endpackage

`default_nettype wire

>>> rtl/fr_queue.sv
// Short register queue between the front and back ends.
// Depends on fr_pkg and fragment_reassembler_defines.svh.
`default_nettype none
`include "fragment_reassembler_defines.svh"

module fr_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire fr_pkg::t_mid i_entry,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_empty,
    output fr_pkg::t_mid      o_head
);
    import fr_pkg::*;

    t_mid                 r_mem [MID_DEPTH];
    logic [MID_PTR_W-1:0] r_wr_ptr;
    logic [MID_PTR_W-1:0] r_rd_ptr;
    logic [MID_CNT_W-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == MID_CNT_W'(MID_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `FR_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)

endmodule

`default_nettype wire

>>> rtl/fr_front.sv
// Front end: takes input items, makes the per-fragment accept decision and
// classifies each byte. Depends on fr_pkg and fragment_reassembler_defines.svh.
`default_nettype none
`include "fragment_reassembler_defines.svh"

module fr_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire fr_pkg::t_frag_in i_frag,
    output logic                  o_push,
    output fr_pkg::t_mid          o_entry
);
    import fr_pkg::*;

    logic        r_assembling;
    logic [7:0]  r_current;
    logic [15:0] r_expected;
    logic        r_frag_acc;
    logic        n_assembling;
    logic [7:0]  n_current;
    logic [15:0] n_expected;
    logic        n_frag_acc;

    logic [7:0]  len_c;
    logic [15:0] off_ext;
    logic        decided;
    logic        dropped;
    logic        wr_cand;
    logic        done;

    assign len_c   = (i_frag.fragment_length > 8'(MAX_FRAGMENT_BYTES))
                   ? 8'(MAX_FRAGMENT_BYTES) : i_frag.fragment_length;
    assign off_ext = {2'b00, i_frag.fragment_offset};

    always_comb begin
        n_assembling = r_assembling;
        n_current    = r_current;
        n_expected   = r_expected;
        n_frag_acc   = r_frag_acc;
        decided      = r_frag_acc;
        dropped      = 1'b0;
        wr_cand      = 1'b0;
        done         = 1'b0;
        if (i_accept) begin
            if (i_frag.byte_index == 8'd0) begin
                decided = 1'b0;
                if (!r_assembling || (i_frag.message_id != r_current)) begin
                    if (i_frag.fragment_offset == 14'd0) begin
                        n_assembling = 1'b1;
                        n_current    = i_frag.message_id;
                        n_expected   = 16'd0;
                    end else begin
                        n_assembling = 1'b0;
                        dropped      = 1'b1;
                    end
                end
                if (!dropped) begin
                    priority if (off_ext < n_expected) begin
                        // duplicate: drop, keep the assembly
                        decided = 1'b0;
                    end else if (off_ext > n_expected) begin
                        // gap: drop and abandon
                        n_assembling = 1'b0;
                    end else begin
                        decided    = 1'b1;
                        n_expected = n_expected + {10'd0, len_c[7:2]};
                    end
                end
            end
            wr_cand = decided && (i_frag.byte_index < len_c);
            done    = decided && i_frag.fragment_end && !i_frag.more_fragments;
            if (done) begin
                n_assembling = 1'b0;
            end
            n_frag_acc = i_frag.fragment_end ? 1'b0 : decided;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assembling <= 1'b0;
            r_current    <= 8'd0;
            r_expected   <= 16'd0;
            r_frag_acc   <= 1'b0;
        end else begin
            r_assembling <= n_assembling;
            r_current    <= n_current;
            r_expected   <= n_expected;
            r_frag_acc   <= n_frag_acc;
        end
    end

    // Only write candidates and completions enter the queue
    assign o_push          = i_accept && (wr_cand || done);
    assign o_entry.wr_cand = wr_cand;
    assign o_entry.done    = done;
    assign o_entry.base    = {i_frag.fragment_offset, 2'b00};
    assign o_entry.idx     = i_frag.byte_index;
    assign o_entry.len     = len_c;
    assign o_entry.data    = i_frag.payload_byte;

    `FR_ASSERT_NEXT(a_done_ends, i_clk, i_rst_n, o_push && o_entry.done, !r_assembling)
    `FR_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_accept && i_frag.fragment_end, !r_frag_acc)

endmodule

`default_nettype wire

>>> rtl/fr_back.sv
// Back end: holds the buffer size, forms addresses and totals, and drives the
// result register. Depends on fr_pkg and fragment_reassembler_defines.svh.
`default_nettype none
`include "fragment_reassembler_defines.svh"

module fr_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_data,
    input  wire logic         i_mid_empty,
    input  wire fr_pkg::t_mid i_head,
    output logic              o_mid_pop,
    input  wire logic         i_pop,
    output logic              o_empty,
    output fr_pkg::t_frag_out o_result
);
    import fr_pkg::*;

    logic [15:0] r_size;
    logic        r_valid;
    t_frag_out   r_out;
    t_frag_out   n_out;

    logic [16:0] addr_w;
    logic [16:0] total_w;
    logic        wv;
    logic        take;

    assign addr_w  = {1'b0, i_head.base} + {9'd0, i_head.idx};
    assign total_w = {1'b0, i_head.base} + {9'd0, i_head.len};
    assign wv      = i_head.wr_cand && (addr_w < {1'b0, r_size});

    always_comb begin
        n_out.write_valid   = wv;
        n_out.write_address = wv ? addr_w[15:0] : 16'd0;
        n_out.write_byte    = wv ? i_head.data : 8'd0;
        n_out.message_done  = i_head.done;
        n_out.total_size    = !i_head.done ? 16'd0
                            : (total_w > {1'b0, r_size}) ? r_size : total_w[15:0];
    end

    assign take      = !i_mid_empty && (!r_valid || i_pop);
    assign o_mid_pop = take;
    assign o_empty   = !r_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_LIMIT;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= (i_cfg_data > SIZE_LIMIT) ? SIZE_LIMIT : i_cfg_data;
            end
            if (take) begin
                r_valid <= n_out.write_valid || n_out.message_done;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    `FR_ASSERT_NOW(a_result_real, i_clk, i_rst_n, r_valid,
                   r_out.write_valid || r_out.message_done)
    `FR_ASSERT_NOW(a_addr_in_buf, i_clk, i_rst_n, r_valid && r_out.write_valid,
                   r_out.write_address < r_size)

endmodule

`default_nettype wire

>>> rtl/fragment_reassembler.sv
// In-order fragment reassembler, top level.
// Depends on fr_pkg, fr_front, fr_queue, fr_back and fragment_reassembler_defines.svh.
//
// Payload bytes come in one per transaction, each tagged with its fragment's
// header; one byte can be taken every clock. The front end decides on the
// first byte of a fragment whether it is kept and classifies every byte; a
// four-entry queue carries classified bytes to the back end, which forms the
// buffer address and the clamped total and loads the result register.
// A queued byte moves on to the result register, and the front keeps taking
// bytes while a result waits, until the queue fills. Bytes that give
// neither a write nor a completion produce no result. buffer_size may be
// written only while the block is idle; values above 65532 act as 65532.
`default_nettype none
`include "fragment_reassembler_defines.svh"

module fragment_reassembler (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input side
    input  wire logic              push,
    output logic                   full,
    input  wire fr_pkg::t_frag_in  i_frag,
    // result side
    output logic                   empty,
    input  wire logic              pop,
    output fr_pkg::t_frag_out      o_result,
    // buffer_size register write
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [15:0]       i_cfg_data
);
    import fr_pkg::*;

    logic accept;
    logic mid_push;
    logic mid_full;
    logic mid_pop;
    logic mid_empty;
    t_mid mid_in;
    t_mid mid_head;

    // The queue is never overrun: input stalls whenever it is full.
    assign full        = mid_full;
    assign accept      = push && !mid_full;
    assign o_cfg_ready = 1'b1;

    fr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_frag  (i_frag),
        .o_push  (mid_push),
        .o_entry (mid_in)
    );

    fr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_entry (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_head  (mid_head)
    );

    fr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_mid_empty(mid_empty),
        .i_head     (mid_head),
        .o_mid_pop  (mid_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

    `FR_ASSERT_NOW(a_push_gated, i_clk, i_rst_n, mid_push, accept)

endmodule

`default_nettype wire
